// ----- rtl/j1708lf_pkg.sv -----
// Package: shared constants, codes and payload types of the J1708 link framer.
`default_nettype none
package j1708lf_pkg;

    localparam int RX_DEPTH = 32;
    localparam int MAX_MSG  = 21;

    localparam int RX_AW   = $clog2(RX_DEPTH);
    localparam int TX_AW   = $clog2(MAX_MSG);
    localparam int LEN_W   = $clog2(MAX_MSG + 1);
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_EOM_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_COLL_WAIT    = 2'd1;
    localparam logic [1:0] REG_MIN_FRAME    = 2'd2;
    localparam logic [1:0] REG_MAX_FRAME    = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_RX   = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_SEND = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_RX      = 3'd0,
        KIND_TX      = 3'd1,
        KIND_OK      = 3'd2,
        KIND_COL     = 3'd3,
        KIND_REFUSED = 3'd4
    } t_kind;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out;

endpackage
`default_nettype wire

// ----- rtl/j1708lf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module j1708lf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/j1708_link_framer_with_echo_check.sv -----
// Top level: J1708 link layer framer with transmit echo check.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  in      | request   | i_in_valid / o_in_ready      | i_in_data  (cmd, data_byte)
//  out     | result    | o_out_valid / i_out_ready    | o_out_data (kind, out_byte, last)
//  cfg     | APB write | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  Ticks that hand on no frame, received bytes and loads are handled in the idle state.
//  Emitting a frame or sending the transmit message waits on the registered read of
//  the receive or transmit RAM for each byte; the echo compare reads both RAMs side
//  by side in the same way. A single result (refusal, confirm, collision) is handed
//  on from its own response state. Requests are taken only in the idle state.
//  Reset is synchronous and active low; the RAMs need no clearing pass.
//  A stalled output holds the result register and the sequencer waits on it.
`default_nettype none
module j1708_link_framer_with_echo_check (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire j1708lf_pkg::t_in                    i_in_data,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output j1708lf_pkg::t_out                        o_out_data,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [j1708lf_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);

    localparam int RX_AW = j1708lf_pkg::RX_AW;
    localparam int TX_AW = j1708lf_pkg::TX_AW;
    localparam int LEN_W = j1708lf_pkg::LEN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_RX,
        ST_EMIT_TX,
        ST_CMP,
        ST_RESP
    } t_state;

    // configuration registers
    logic [15:0] r_eom_timeout;
    logic [15:0] r_coll_wait;
    logic [4:0]  r_min_len;
    logic [4:0]  r_max_len;

    // sequencer and link state
    t_state              r_state,      n_state;
    logic [LEN_W-1:0]    r_idx,        n_idx;
    logic [LEN_W-1:0]    r_len,        n_len;
    logic                r_primed,     n_primed;
    j1708lf_pkg::t_kind  r_resp_kind,  n_resp_kind;
    logic                r_out_valid,  n_out_valid;
    j1708lf_pkg::t_out   r_out,        n_out;
    logic [RX_AW-1:0]    r_rx_count,   n_rx_count;
    logic [15:0]         r_eom_left,   n_eom_left;
    logic                r_eom_run,    n_eom_run;
    logic [LEN_W-1:0]    r_tx_len,     n_tx_len;
    logic                r_await,      n_await;
    logic [15:0]         r_col_left,   n_col_left;

    logic                w_cfg_wr;
    logic                w_in_acc;
    logic                w_slot;
    logic                w_rx_we;
    logic                w_tx_we;
    logic [7:0]          w_rx_rdata;
    logic [7:0]          w_tx_rdata;
    logic [15:0]         w_idx16;
    logic [15:0]         w_len16;
    logic [15:0]         w_tx16;
    logic                w_len_ok;
    logic                w_last;
    logic                w_refuse;

    // ---------------------------------------------------------------- config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            j1708lf_pkg::REG_EOM_TIMEOUT: prdata = {16'd0, r_eom_timeout};
            j1708lf_pkg::REG_COLL_WAIT:   prdata = {16'd0, r_coll_wait};
            j1708lf_pkg::REG_MIN_FRAME:   prdata = {27'd0, r_min_len};
            j1708lf_pkg::REG_MAX_FRAME:   prdata = {27'd0, r_max_len};
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- handshakes
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // result register free this cycle: empty, or being taken now
    assign w_slot      = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- memories
    // Receive bytes land at the fill count; drop them once the count reaches RX_DEPTH - 1.
    assign w_rx_we = w_in_acc && (i_in_data.cmd == j1708lf_pkg::CMD_RX) &&
                     (r_rx_count < RX_AW'(j1708lf_pkg::RX_DEPTH - 1));
    // Transmit bytes append unless an echo is pending or the message is full.
    assign w_tx_we = w_in_acc && (i_in_data.cmd == j1708lf_pkg::CMD_LOAD) &&
                     !r_await && (r_tx_len < LEN_W'(j1708lf_pkg::MAX_MSG));

    assign w_idx16 = 16'(r_idx);

    j1708lf_ram #(
        .WIDTH (8),
        .DEPTH (j1708lf_pkg::RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx_we),
        .i_waddr (r_rx_count),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (w_idx16[RX_AW-1:0]),
        .o_rdata (w_rx_rdata)
    );

    j1708lf_ram #(
        .WIDTH (8),
        .DEPTH (j1708lf_pkg::MAX_MSG)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (r_tx_len[TX_AW-1:0]),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (r_idx[TX_AW-1:0]),
        .o_rdata (w_tx_rdata)
    );

    // ---------------------------------------------------------------- decisions
    assign w_len16  = 16'(r_rx_count);
    assign w_tx16   = 16'(r_tx_len);
    // frame length must sit inside [min, max] and fit a message
    assign w_len_ok = (w_len16 >= 16'(r_min_len)) && (w_len16 <= 16'(r_max_len)) &&
                      (w_len16 <= 16'(j1708lf_pkg::MAX_MSG));
    assign w_last   = ((r_idx + LEN_W'(1)) == r_len);
    // refuse a send while nothing is loaded, an echo is pending, the collision
    // wait runs or the receiver is busy
    assign w_refuse = (r_tx_len == '0) || r_await || (r_col_left != 16'd0) ||
                      (r_rx_count != '0) || r_eom_run;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_primed    = r_primed;
        n_resp_kind = r_resp_kind;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_rx_count  = r_rx_count;
        n_eom_left  = r_eom_left;
        n_eom_run   = r_eom_run;
        n_tx_len    = r_tx_len;
        n_await     = r_await;
        n_col_left  = r_col_left;

        // drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.cmd)
                        j1708lf_pkg::CMD_TICK: begin
                            // collision countdown steps before the frame timer
                            if (r_col_left != 16'd0) begin
                                n_col_left = r_col_left - 16'd1;
                            end
                            if (r_eom_run) begin
                                if (r_eom_left <= 16'd1) begin
                                    n_eom_left = 16'd0;
                                    n_eom_run  = 1'b0;
                                    n_rx_count = '0;
                                    n_idx      = '0;
                                    n_primed   = 1'b0;
                                    n_len      = w_len16[LEN_W-1:0];
                                    if (w_len_ok) begin
                                        if (r_await) begin
                                            if (w_len16 != w_tx16) begin
                                                n_await     = 1'b0;
                                                n_col_left  = r_coll_wait;
                                                n_resp_kind = j1708lf_pkg::KIND_COL;
                                                n_state     = ST_RESP;
                                            end else begin
                                                n_state = ST_CMP;
                                            end
                                        end else if (r_rx_count != '0) begin
                                            n_state = ST_EMIT_RX;
                                        end
                                    end
                                end else begin
                                    n_eom_left = r_eom_left - 16'd1;
                                end
                            end
                        end
                        j1708lf_pkg::CMD_RX: begin
                            if (w_rx_we) begin
                                n_rx_count = r_rx_count + RX_AW'(1);
                            end
                            // every byte restarts the end-of-message timer
                            n_eom_left = r_eom_timeout;
                            n_eom_run  = 1'b1;
                        end
                        j1708lf_pkg::CMD_LOAD: begin
                            if (w_tx_we) begin
                                n_tx_len = r_tx_len + LEN_W'(1);
                            end
                        end
                        default: begin
                            if (w_refuse) begin
                                n_resp_kind = j1708lf_pkg::KIND_REFUSED;
                                n_state     = ST_RESP;
                            end else begin
                                n_idx    = '0;
                                n_primed = 1'b0;
                                n_len    = r_tx_len;
                                n_await  = 1'b1;
                                n_state  = ST_EMIT_TX;
                            end
                        end
                    endcase
                end
            end

            ST_EMIT_RX, ST_EMIT_TX: begin
                // wait for the registered RAM read, then hand the byte on once the result register is free
                if (!r_primed) begin
                    n_primed = 1'b1;
                end else if (w_slot) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = (r_state == ST_EMIT_RX) ? j1708lf_pkg::KIND_RX
                                                                 : j1708lf_pkg::KIND_TX;
                    n_out.out_byte    = (r_state == ST_EMIT_RX) ? w_rx_rdata : w_tx_rdata;
                    n_out.last        = w_last;
                    n_idx             = r_idx + LEN_W'(1);
                    n_primed          = 1'b0;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_CMP: begin
                // walk echo and message side by side; stop at the first mismatch
                if (!r_primed) begin
                    n_primed = 1'b1;
                end else if (w_rx_rdata != w_tx_rdata) begin
                    n_await     = 1'b0;
                    n_col_left  = r_coll_wait;
                    n_resp_kind = j1708lf_pkg::KIND_COL;
                    n_state     = ST_RESP;
                end else if (w_last) begin
                    n_await     = 1'b0;
                    n_tx_len    = '0;
                    n_resp_kind = j1708lf_pkg::KIND_OK;
                    n_state     = ST_RESP;
                end else begin
                    n_idx    = r_idx + LEN_W'(1);
                    n_primed = 1'b0;
                end
            end

            ST_RESP: begin
                if (w_slot) begin
                    n_out_valid    = 1'b1;
                    n_out.kind     = r_resp_kind;
                    n_out.out_byte = 8'd0;
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_primed      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rx_count    <= '0;
            r_eom_left    <= 16'd0;
            r_eom_run     <= 1'b0;
            r_tx_len      <= '0;
            r_await       <= 1'b0;
            r_col_left    <= 16'd0;
            r_eom_timeout <= 16'd55;
            r_coll_wait   <= 16'd135;
            r_min_len     <= 5'd2;
            r_max_len     <= 5'd21;
        end else begin
            r_state     <= n_state;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
            r_rx_count  <= n_rx_count;
            r_eom_left  <= n_eom_left;
            r_eom_run   <= n_eom_run;
            r_tx_len    <= n_tx_len;
            r_await     <= n_await;
            r_col_left  <= n_col_left;
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    j1708lf_pkg::REG_EOM_TIMEOUT: r_eom_timeout <= pwdata[15:0];
                    j1708lf_pkg::REG_COLL_WAIT:   r_coll_wait   <= pwdata[15:0];
                    j1708lf_pkg::REG_MIN_FRAME:   r_min_len     <= pwdata[4:0];
                    j1708lf_pkg::REG_MAX_FRAME:   r_max_len     <= pwdata[4:0];
                    default: begin
                    end
                endcase
            end
        end
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_resp_kind <= n_resp_kind;
        r_out       <= n_out;
    end

endmodule
`default_nettype wire
